[hw/rtl/mamt_pkg.sv]
// ----------------------------------------------------------------------------
// mamt_pkg
// shared types, codes and defaults for the multi alarm match table
// ----------------------------------------------------------------------------
package mamt_pkg;

    localparam int MAX_ALARMS_DEF = 8;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] MODE_DAILY    = 2'd0;
    localparam logic [1:0] MODE_WEEKDAYS = 2'd1;
    localparam logic [1:0] MODE_ONCE     = 2'd2;

    localparam logic [4:0] DEF_HOUR     = 5'd7;
    localparam logic [5:0] DEF_MINUTE   = 6'd0;
    localparam logic [2:0] WORKDAY_LO   = 3'd1;
    localparam logic [2:0] WORKDAY_HI   = 3'd5;
    localparam logic [4:0] SEEN_HOUR_RST   = 5'd31;
    localparam logic [5:0] SEEN_MINUTE_RST = 6'd63;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] slot_index;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
        logic       set_enabled;
        logic [1:0] set_repeat_mode;
    } t_cmd_word;

    typedef struct packed {
        logic       op_ok;
        logic       alarm_fired;
        logic [5:0] fired_slot;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
        logic       entry_enabled;
        logic [1:0] entry_repeat_mode;
        logic [6:0] entries_in_use;
    } t_res_word;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic [1:0] mode;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/mamt_cmd_if.sv]
// ----------------------------------------------------------------------------
// mamt_cmd_if
// valid/ready channel carrying one command word
// ----------------------------------------------------------------------------
interface mamt_cmd_if
    import mamt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cmd_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mamt_res_if.sv]
// ----------------------------------------------------------------------------
// mamt_res_if
// valid/ready channel carrying one result word
// ----------------------------------------------------------------------------
interface mamt_res_if
    import mamt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/multi_alarm_match_table_top.sv]
// ----------------------------------------------------------------------------
// multi_alarm_match_table_top
// alarm table with add, remove, write, read and per-minute tick matching
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives exactly one result word.
// Entries live in a single-port-write, registered-read memory walked by a
// small sequencer, one entry per cycle. Add, write, unknown commands and
// ticks that do not scan go from idle straight to done; a valid read passes
// through a read state; a scanning tick checks entries in order up to the
// first hit (all entries in use when nothing matches); a valid remove shifts
// the entries above slot_index down by one. The result sits in an output
// register, and a new word is accepted once the sequencer is back in idle.
// ----------------------------------------------------------------------------
module multi_alarm_match_table_top
    import mamt_pkg::*;
#(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mamt_cmd_if.sink   i_cmd,
    mamt_res_if.source o_res
);

    localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CW = $clog2(MAX_ALARMS + 1);

    t_state          r_state, n_state;
    t_entry          r_mem [MAX_ALARMS];
    t_entry          r_rdata;
    t_cmd_word       r_item, n_item;
    logic [CW-1:0]   r_total, n_total;
    logic [CW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_ci, n_ci;
    logic            r_pend, n_pend;
    logic [4:0]      r_seen_hour, n_seen_hour;
    logic [5:0]      r_seen_minute, n_seen_minute;
    logic            r_fired_min, n_fired_min;
    logic            r_ok, n_ok;
    logic            r_fired, n_fired;
    logic [5:0]      r_slot, n_slot;
    t_entry          r_rd, n_rd;
    logic            r_out_valid, n_out_valid;
    t_res_word       r_out, n_out;

    logic            accept;
    logic            idx_valid;
    logic            new_minute;
    logic            fired_after;
    logic            tick_scan;
    logic            scan_more;
    logic            scan_hit;
    logic            day_ok;
    logic [CW-1:0]   i_plus;
    logic            shift_more;
    logic            out_free;
    logic [AW-1:0]   rd_addr;
    logic            we;
    logic [AW-1:0]   wa;
    t_entry          wd;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign idx_valid   = i_cmd.data.slot_index < 8'(r_total);
    assign new_minute  = (r_seen_hour != i_cmd.data.hour) || (r_seen_minute != i_cmd.data.minute);
    assign fired_after = new_minute ? 1'b0 : r_fired_min;
    assign tick_scan   = (i_cmd.data.second == 6'd0) && !fired_after;
    assign scan_more   = r_i < r_total;
    assign day_ok      = (r_rdata.mode != MODE_WEEKDAYS) ||
                         ((r_item.weekday >= WORKDAY_LO) && (r_item.weekday <= WORKDAY_HI));
    assign scan_hit    = r_pend && r_rdata.enabled && (r_rdata.hour == r_item.hour) &&
                         (r_rdata.minute == r_item.minute) && day_ok;
    assign i_plus      = r_i + CW'(1);
    assign shift_more  = i_plus < r_total;
    assign out_free    = !r_out_valid || o_res.ready;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.data.cmd)
                        CMD_TICK:   n_state = tick_scan ? ST_SCAN : ST_DONE;
                        CMD_REMOVE: n_state = idx_valid ? ST_SHIFT : ST_DONE;
                        CMD_READ:   n_state = idx_valid ? ST_READ : ST_DONE;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_hit || !scan_more) n_state = ST_DONE;
            end
            ST_SHIFT: begin
                if (!shift_more) n_state = ST_DONE;
            end
            ST_READ: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_item        = r_item;
        n_total       = r_total;
        n_i           = r_i;
        n_ci          = r_ci;
        n_pend        = r_pend;
        n_seen_hour   = r_seen_hour;
        n_seen_minute = r_seen_minute;
        n_fired_min   = r_fired_min;
        n_ok          = r_ok;
        n_fired       = r_fired;
        n_slot        = r_slot;
        n_rd          = r_rd;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out         = r_out;
        rd_addr       = i_cmd.data.slot_index[AW-1:0];
        we            = 1'b0;
        wa            = i_cmd.data.slot_index[AW-1:0];
        wd            = r_rdata;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item  = i_cmd.data;
                    n_ok    = 1'b0;
                    n_fired = 1'b0;
                    n_slot  = 6'd0;
                    n_rd    = '0;
                    n_i     = '0;
                    n_pend  = 1'b0;
                    case (i_cmd.data.cmd)
                        CMD_TICK: begin
                            if (i_cmd.data.second == 6'd0) begin
                                n_seen_hour   = i_cmd.data.hour;
                                n_seen_minute = i_cmd.data.minute;
                                n_fired_min   = fired_after;
                            end
                        end
                        CMD_ADD: begin
                            if (r_total < CW'(MAX_ALARMS)) begin
                                we      = 1'b1;
                                wa      = r_total[AW-1:0];
                                wd      = '{hour: DEF_HOUR, minute: DEF_MINUTE,
                                            enabled: 1'b1, mode: MODE_DAILY};
                                n_total = r_total + CW'(1);
                                n_ok    = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            n_i  = i_cmd.data.slot_index[CW-1:0];
                            n_ok = idx_valid;
                        end
                        CMD_WRITE: begin
                            if (idx_valid) begin
                                we   = 1'b1;
                                wd   = '{hour: i_cmd.data.hour, minute: i_cmd.data.minute,
                                         enabled: i_cmd.data.set_enabled,
                                         mode: (i_cmd.data.set_repeat_mode <= MODE_ONCE) ?
                                               i_cmd.data.set_repeat_mode : MODE_DAILY};
                                n_ok = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            n_ok = idx_valid;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_addr = r_i[AW-1:0];
                if (scan_hit) begin
                    n_fired_min = 1'b1;
                    n_fired     = 1'b1;
                    n_slot      = 6'(r_ci);
                    n_pend      = 1'b0;
                    if (r_rdata.mode == MODE_ONCE) begin
                        we         = 1'b1;
                        wa         = r_ci;
                        wd         = r_rdata;
                        wd.enabled = 1'b0;
                    end
                end else if (scan_more) begin
                    n_ci   = r_i[AW-1:0];
                    n_pend = 1'b1;
                    n_i    = i_plus;
                end else begin
                    n_pend = 1'b0;
                end
            end
            ST_SHIFT: begin
                rd_addr = i_plus[AW-1:0];
                if (r_pend) begin
                    we = 1'b1;
                    wa = r_ci;
                    wd = r_rdata;
                end
                if (shift_more) begin
                    n_ci   = r_i[AW-1:0];
                    n_pend = 1'b1;
                    n_i    = i_plus;
                end else begin
                    n_pend  = 1'b0;
                    n_total = r_total - CW'(1);
                end
            end
            ST_READ: begin
                n_rd = r_rdata;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{op_ok: r_ok, alarm_fired: r_fired, fired_slot: r_slot,
                                    entry_hour: r_rd.hour, entry_minute: r_rd.minute,
                                    entry_enabled: r_rd.enabled,
                                    entry_repeat_mode: r_rd.mode,
                                    entries_in_use: 7'(r_total)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_total       <= '0;
            r_pend        <= 1'b0;
            r_seen_hour   <= SEEN_HOUR_RST;
            r_seen_minute <= SEEN_MINUTE_RST;
            r_fired_min   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_total       <= n_total;
            r_pend        <= n_pend;
            r_seen_hour   <= n_seen_hour;
            r_seen_minute <= n_seen_minute;
            r_fired_min   <= n_fired_min;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_i     <= n_i;
        r_ci    <= n_ci;
        r_ok    <= n_ok;
        r_fired <= n_fired;
        r_slot  <= n_slot;
        r_rd    <= n_rd;
        r_out   <= n_out;
    end

endmodule

[hw/rtl/mamt_checker.sv]
// ----------------------------------------------------------------------------
// mamt_checker
// port-level assertions for the multi alarm match table
// ----------------------------------------------------------------------------
module mamt_checker
    import mamt_pkg::*;
#(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_res_word i_out_data
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // one word in flight: ready drops right after accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after accept");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.entries_in_use <= 7'(MAX_ALARMS))
        else $error("entries in use above table size");

    a_fire_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.alarm_fired |->
            !i_out_data.op_ok && (7'(i_out_data.fired_slot) < i_out_data.entries_in_use))
        else $error("fired slot outside table or op_ok on tick");

endmodule

bind multi_alarm_match_table_top mamt_checker #(
    .MAX_ALARMS (MAX_ALARMS)
) u_mamt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
